/* rtl/fsr_pkg.sv */
// Shared types, constants and helpers for the framebuffer scanout converter.
// Used by fsr_front, fsr_queue, fsr_back and framebuffer_scanout_to_rgba.
package fsr_pkg;

  localparam int unsigned MaxDimDefault = 4096;
  localparam int unsigned BarCount      = 8;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [12:0] FallbackWidth  = 13'd1024;
  localparam logic [15:0] FallbackHeight = 16'd768;
  localparam logic [7:0]  AlphaOpaque    = 8'hFF;

  typedef enum logic [1:0] {
    DEPTH_GRAY8  = 2'd0,
    DEPTH_RGB565 = 2'd1,
    DEPTH_RGB24  = 2'd2,
    DEPTH_RGBA32 = 2'd3
  } depth_e;

  typedef enum logic [1:0] {
    CFG_DEPTH   = 2'd0,
    CFG_WIDTH   = 2'd1,
    CFG_HEIGHT  = 2'd2,
    CFG_PATTERN = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    depth_e      depth;
    logic [12:0] width;
    logic [15:0] height;
    logic        pattern;
  } cfg_t;

  // One queued pixel job: a pattern pixel or a complete source pixel.
  typedef struct packed {
    logic   pattern;
    depth_e depth;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] last;
  } job_t;

  // Bad geometry selects 1024x768 at 32bpp.
  function automatic logic use_fallback(input logic [12:0] w, input logic [15:0] h,
                                        input int unsigned max_dim);
    logic res;
    res = (w == 13'd0) || (h == 16'd0) ||
          (32'(w) > max_dim) || (32'(h) > max_dim);
    return res;
  endfunction

  // Color bars: red, yellow, green, cyan, blue, magenta, white, black.
  function automatic logic [23:0] bar_color(input logic [2:0] bar);
    logic [23:0] rgb;
    case (bar)
      3'd0:    rgb = 24'hFF0000;
      3'd1:    rgb = 24'hFFFF00;
      3'd2:    rgb = 24'h00FF00;
      3'd3:    rgb = 24'h00FFFF;
      3'd4:    rgb = 24'h0000FF;
      3'd5:    rgb = 24'hFF00FF;
      3'd6:    rgb = 24'hFFFFFF;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

/* rtl/fsr_front.sv */
// Front end: accepts bytes, gathers them into source pixels, issues jobs.
// Depends on fsr_pkg.
module fsr_front #(
  parameter int unsigned MAX_DIM = fsr_pkg::MaxDimDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fsr_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    byte_value_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output fsr_pkg::job_t q_job_o
);

  logic [1:0]     phase_q, phase_d;
  logic [23:0]    held_q, held_d;
  fsr_pkg::depth_e depth_eff;
  logic           accept;
  logic           complete;

  assign depth_eff = fsr_pkg::use_fallback(cfg_i.width, cfg_i.height, MAX_DIM)
                   ? fsr_pkg::DEPTH_RGBA32 : cfg_i.depth;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  // Phase at or past the last byte of the pixel finishes it.
  assign complete   = cfg_i.pattern || (phase_q >= depth_eff);
  assign q_push_o   = accept && complete;

  always_comb begin
    q_job_o.pattern = cfg_i.pattern;
    q_job_o.depth   = depth_eff;
    q_job_o.b0      = held_q[7:0];
    q_job_o.b1      = held_q[15:8];
    q_job_o.b2      = held_q[23:16];
    q_job_o.last    = byte_value_i;
  end

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    if (accept) begin
      if (complete) begin
        phase_d = 2'd0;
      end else begin
        case (phase_q)
          2'd0:    held_d[7:0]   = byte_value_i;
          2'd1:    held_d[15:8]  = byte_value_i;
          default: held_d[23:16] = byte_value_i;
        endcase
        phase_d = phase_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      held_q  <= 24'd0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

/* rtl/fsr_queue.sv */
// Small job queue between front and back ends.
// Depends on fsr_pkg for the job type and depth.
module fsr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fsr_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output fsr_pkg::job_t job_o
);

  localparam int unsigned PtrW = $clog2(fsr_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(fsr_pkg::QueueDepth + 1);

  fsr_pkg::job_t mem_q [fsr_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic do_push, do_pop;

  assign full_o  = (count_q == CntW'(fsr_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == fsr_pkg::QueueDepth - 1) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == fsr_pkg::QueueDepth - 1) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

/* rtl/fsr_back.sv */
// Back end: converts jobs to RGBA, tracks row/column, drives the output register.
// Depends on fsr_pkg.
module fsr_back #(
  parameter int unsigned MAX_DIM = fsr_pkg::MaxDimDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fsr_pkg::cfg_t cfg_i,
  input  logic          q_empty_i,
  input  fsr_pkg::job_t q_job_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    red_o,
  output logic [7:0]    green_o,
  output logic [7:0]    blue_o,
  output logic [7:0]    alpha_o,
  output logic          row_end_o,
  output logic          frame_end_o
);

  logic [12:0] col_q, col_d;
  logic [12:0] row_q, row_d;
  logic        out_valid_q;
  logic [7:0]  red_q, green_q, blue_q, alpha_q;
  logic        row_end_q, frame_end_q;

  logic        fallback;
  logic [12:0] w_eff;
  logic [15:0] h_eff;
  logic [12:0] x;
  logic [15:0] x8;
  logic [2:0]  bar;
  logic [23:0] bar_rgb;
  logic [15:0] px;
  logic [7:0]  r, g, b, a;
  logic        row_end, frame_end;

  assign fallback = fsr_pkg::use_fallback(cfg_i.width, cfg_i.height, MAX_DIM);
  assign w_eff    = fallback ? fsr_pkg::FallbackWidth  : cfg_i.width;
  assign h_eff    = fallback ? fsr_pkg::FallbackHeight : cfg_i.height;

  // Pop whenever the queue holds a job and the output register is free or being drained.
  assign q_pop_o = !q_empty_i && (!out_valid_q || !out_stall_i);

  // Bar index = floor(8x / w): count bar edges k*w at or below 8x.
  always_comb begin
    x   = (col_q >= w_eff) ? (w_eff - 13'd1) : col_q;
    x8  = {x, 3'b000};
    bar = 3'd0;
    for (int k = 1; k < int'(fsr_pkg::BarCount); k++) begin
      if (x8 >= 16'(int'(w_eff) * k)) begin
        bar = bar + 3'd1;
      end
    end
    bar_rgb = fsr_pkg::bar_color(bar);
  end

  always_comb begin
    px = {q_job_i.last, q_job_i.b0};
    if (q_job_i.pattern) begin
      r = bar_rgb[23:16];
      g = bar_rgb[15:8];
      b = bar_rgb[7:0];
      a = fsr_pkg::AlphaOpaque;
    end else begin
      unique case (q_job_i.depth)
        fsr_pkg::DEPTH_GRAY8: begin
          r = q_job_i.last;
          g = q_job_i.last;
          b = q_job_i.last;
          a = fsr_pkg::AlphaOpaque;
        end
        fsr_pkg::DEPTH_RGB565: begin
          r = {px[15:11], 3'b000};
          g = {px[10:5], 2'b00};
          b = {px[4:0], 3'b000};
          a = fsr_pkg::AlphaOpaque;
        end
        fsr_pkg::DEPTH_RGB24: begin
          r = q_job_i.b0;
          g = q_job_i.b1;
          b = q_job_i.last;
          a = fsr_pkg::AlphaOpaque;
        end
        default: begin
          r = q_job_i.b0;
          g = q_job_i.b1;
          b = q_job_i.b2;
          a = q_job_i.last;
        end
      endcase
    end
  end

  // Counters past the end (after a geometry change) count as the last position.
  always_comb begin
    row_end   = ({1'b0, col_q} + 14'd1) >= {1'b0, w_eff};
    frame_end = 1'b0;
    col_d     = col_q;
    row_d     = row_q;
    if (q_pop_o) begin
      if (row_end) begin
        col_d = 13'd0;
        if (({4'd0, row_q} + 17'd1) >= {1'b0, h_eff}) begin
          frame_end = 1'b1;
          row_d     = 13'd0;
        end else begin
          row_d = row_q + 13'd1;
        end
      end else begin
        col_d = col_q + 13'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= 13'd0;
      row_q       <= 13'd0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      red_q       <= r;
      green_q     <= g;
      blue_q      <= b;
      alpha_q     <= a;
      row_end_q   <= row_end;
      frame_end_q <= frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_o     = alpha_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

endmodule

/* rtl/framebuffer_scanout_to_rgba.sv */
// Top level of the framebuffer scanout to RGBA8888 converter.
// Holds the configuration registers; instantiates fsr_front, fsr_queue, fsr_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / byte_value_i) carries one
//   framebuffer byte per beat in row order. A beat is taken when valid is
//   high and stall is low. Bytes that do not finish a pixel produce nothing.
//   Output channel (out_valid_o / out_stall_i) carries one RGBA8888 pixel per
//   beat, with row_end_o and frame_end_o marking the last pixel of a row and
//   of the frame. In pattern mode every input beat yields a color bar pixel.
//   Config port (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i) is
//   always ready; write only while the block is idle.
//   Throughput: one input beat per cycle while in_stall_o is low, set by the
//   front end's single byte path; a finished pixel passes through the job
//   queue and then the output register before it appears at the output.
//   Receiver stall: the output register holds its pixel, the two-entry job
//   queue fills, and then in_stall_o rises; nothing is dropped.
//   Reset: 32bpp, 1024x768, pattern off, counters and byte phase cleared,
//   output and queue empty.
module framebuffer_scanout_to_rgba #(
  parameter int unsigned MAX_DIM = fsr_pkg::MaxDimDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  // pixel output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic        row_end_o,
  output logic        frame_end_o
);

  fsr_pkg::cfg_t cfg_q, cfg_d;
  fsr_pkg::job_t push_job, head_job;
  logic q_push, q_pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  // Register file: one field per index, fields truncated to their widths.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (fsr_pkg::cfg_reg_e'(cfg_index_i))
        fsr_pkg::CFG_DEPTH:   cfg_d.depth   = fsr_pkg::depth_e'(cfg_data_i[1:0]);
        fsr_pkg::CFG_WIDTH:   cfg_d.width   = cfg_data_i[12:0];
        fsr_pkg::CFG_HEIGHT:  cfg_d.height  = cfg_data_i;
        fsr_pkg::CFG_PATTERN: cfg_d.pattern = cfg_data_i[0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth   <= fsr_pkg::DEPTH_RGBA32;
      cfg_q.width   <= fsr_pkg::FallbackWidth;
      cfg_q.height  <= fsr_pkg::FallbackHeight;
      cfg_q.pattern <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fsr_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_value_i (byte_value_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_job_o      (push_job)
  );

  fsr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (head_job)
  );

  fsr_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_job_i     (head_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_o     (alpha_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

endmodule

/* dv/framebuffer_scanout_to_rgba_tb.sv */
// Self-checking testbench for framebuffer_scanout_to_rgba: byte stream in, RGBA8888 pixels out.
// Needs fsr_pkg (depth and config register codes) and the RTL of the converter.
module framebuffer_scanout_to_rgba_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxDim      = fsr_pkg::MaxDimDefault;
  localparam int          SettleCycles = 8;        // output register plus two-entry queue
  localparam int          RandomBytes  = 1100;
  localparam int          MaxReports   = 10;
  // Bar colors packed low to high: red, yellow, green, cyan, blue, magenta, white, black.
  localparam logic [8*24-1:0] BarTable = {24'h000000, 24'hFFFFFF, 24'hFF00FF, 24'h0000FF,
                                          24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       frame_end;
  } rgba_t;

  // DUT-facing signals; every input has a known value from time zero.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = fsr_pkg::CFG_DEPTH;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  red, green, blue, alpha;
  logic        row_end, frame_end;

  // Mirror of the converter: configuration registers and scan state.
  fsr_pkg::depth_e cur_depth;
  logic [12:0] cur_width;
  logic [15:0] cur_height;
  logic        cur_pattern;
  logic [1:0]  phase;
  logic [23:0] held;
  logic [12:0] col;
  logic [12:0] row;

  logic [7:0] fb_bytes[$];    // framebuffer bytes not yet offered to the DUT
  rgba_t      rgba_due[$];    // pixels the DUT still owes, oldest first

  int  mismatches = 0;
  bit  byte_taken = 1'b0;     // set at the rising edge, consumed at the falling edge
  bit  pix_taken = 1'b0;
  int  src_wait = 0;
  int  sink_wait = 0;
  bit  quiet_src = 1'b0;      // phases with no idling on that side
  bit  quiet_sink = 1'b0;

  framebuffer_scanout_to_rgba DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .byte_value_i (byte_value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue),
    .alpha_o      (alpha),
    .row_end_o    (row_end),
    .frame_end_o  (frame_end)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Mostly short waits, sometimes long ones, none at all in quiet phases.
  function automatic int draw_wait(input bit quiet);
    int n;
    n = 0;
    if (!quiet) begin
      case ($urandom_range(0, 3))
        0: n = $urandom_range(0, 16);
        1: n = $urandom_range(0, 2);
        default: n = 0;
      endcase
    end
    return n;
  endfunction

  // Scan one accepted byte; queue the pixel it finishes, if any.
  task automatic convert_byte(input logic [7:0] b);
    int unsigned w, h, nbytes, x, bar;
    logic [23:0] rgb;
    logic [15:0] word;
    rgba_t       px;
    w      = cur_width;
    h      = cur_height;
    nbytes = int'(cur_depth) + 1;
    // Bad geometry forces 1024x768 at 32bpp regardless of the depth register.
    if (w == 0 || h == 0 || w > MaxDim || h > MaxDim) begin
      w      = fsr_pkg::FallbackWidth;
      h      = fsr_pkg::FallbackHeight;
      nbytes = 4;
    end
    px = '0;
    if (cur_pattern) begin
      // Byte is ignored; a column past the row end is treated as the last column.
      x   = (col >= w) ? w - 1 : col;
      bar = x * fsr_pkg::BarCount / w;
      if (bar > fsr_pkg::BarCount - 1) bar = fsr_pkg::BarCount - 1;
      rgb       = BarTable[bar*24 +: 24];
      px.red    = rgb[23:16];
      px.green  = rgb[15:8];
      px.blue   = rgb[7:0];
      px.alpha  = fsr_pkg::AlphaOpaque;
      phase     = '0;
    end else begin
      // Pixel not complete yet: keep the byte and stay silent.
      if (phase + 1 < nbytes) begin
        held[8*phase +: 8] = b;
        phase = phase + 2'd1;
        return;
      end
      // Current byte closes the pixel, even when the phase ran past the
      // pixel size after a depth change; stale held bytes are used as is.
      case (nbytes)
        1: begin
          px.red   = b;
          px.green = b;
          px.blue  = b;
          px.alpha = fsr_pkg::AlphaOpaque;
        end
        2: begin
          word     = {b, held[7:0]};   // little-endian RGB565
          px.red   = {word[15:11], 3'b000};
          px.green = {word[10:5], 2'b00};
          px.blue  = {word[4:0], 3'b000};
          px.alpha = fsr_pkg::AlphaOpaque;
        end
        3: begin
          px.red   = held[7:0];
          px.green = held[15:8];
          px.blue  = b;
          px.alpha = fsr_pkg::AlphaOpaque;
        end
        default: begin
          px.red   = held[7:0];
          px.green = held[15:8];
          px.blue  = held[23:16];
          px.alpha = b;
        end
      endcase
      phase = '0;
    end
    // Counters left beyond the frame by a config change count as the last position.
    px.row_end = (col + 1 >= w);
    if (px.row_end) begin
      col = '0;
      if (row + 1 >= h) begin
        px.frame_end = 1'b1;
        row          = '0;
      end else begin
        row = row + 13'd1;
      end
    end else begin
      col = col + 13'd1;
    end
    rgba_due.push_back(px);
  endtask

  // Byte side: predict on every accepted beat. Pixel side: check every accepted beat.
  always @(posedge clk) begin
    rgba_t want, seen;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        byte_taken = 1'b1;
        convert_byte(byte_value);
      end
      if (out_valid && !out_stall) begin
        pix_taken = 1'b1;
        seen = {red, green, blue, alpha, row_end, frame_end};
        if (rgba_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t unexpected pixel %h_%h_%h_%h row_end %b frame_end %b", $time,
                     red, green, blue, alpha, row_end, frame_end);
        end else begin
          want = rgba_due.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%0t mismatch: want %h_%h_%h_%h re%b fe%b, got %h_%h_%h_%h re%b fe%b",
                       $time, want.red, want.green, want.blue, want.alpha, want.row_end,
                       want.frame_end, red, green, blue, alpha, row_end, frame_end);
          end
        end
      end
    end
  end

  // Byte driver: holds a beat until taken, then idles for a drawn number of cycles.
  always @(negedge clk) begin
    if (byte_taken || !in_valid) begin
      byte_taken = 1'b0;
      if (src_wait > 0) begin
        src_wait--;
        in_valid <= 1'b0;
      end else if (fb_bytes.size() > 0) begin
        in_valid   <= 1'b1;
        byte_value <= fb_bytes.pop_front();
        src_wait   = draw_wait(quiet_src);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Pixel sink: after each taken beat, stall for a drawn number of cycles.
  always @(negedge clk) begin
    if (pix_taken) begin
      pix_taken = 1'b0;
      sink_wait = draw_wait(quiet_sink);
    end
    if (sink_wait > 0) begin
      sink_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One register write; the mirror takes the masked value once the beat is accepted.
  task automatic write_reg(input fsr_pkg::cfg_reg_e idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fsr_pkg::CFG_DEPTH:   cur_depth   = fsr_pkg::depth_e'(data[1:0]);
      fsr_pkg::CFG_WIDTH:   cur_width   = data[12:0];
      fsr_pkg::CFG_HEIGHT:  cur_height  = data;
      fsr_pkg::CFG_PATTERN: cur_pattern = data[0];
      default: ;
    endcase
  endtask

  // Writes the registers picked by mask; unused upper data bits carry noise.
  task automatic configure(input logic [3:0] mask, input fsr_pkg::depth_e d,
                           input logic [12:0] w, input logic [15:0] h, input logic pat);
    logic [15:0] junk;
    junk = $urandom;
    if (mask[fsr_pkg::CFG_DEPTH])   write_reg(fsr_pkg::CFG_DEPTH, {junk[15:2], d});
    if (mask[fsr_pkg::CFG_WIDTH])   write_reg(fsr_pkg::CFG_WIDTH, {junk[2:0], w});
    if (mask[fsr_pkg::CFG_HEIGHT])  write_reg(fsr_pkg::CFG_HEIGHT, h);
    if (mask[fsr_pkg::CFG_PATTERN]) write_reg(fsr_pkg::CFG_PATTERN, {junk[14:0], pat});
    if (mask != '0) begin
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
    // Bytes are queued at a rising edge so the driver never races the fill.
    @(posedge clk);
  endtask

  // Wait for every byte to go in and every owed pixel to come out, then let
  // a partly assembled pixel settle before the next register write. The
  // check runs just after the falling edge so the driver's update is seen.
  task automatic settle();
    int guard;
    guard = 0;
    while ((fb_bytes.size() > 0 || in_valid || rgba_due.size() > 0) && guard < 20000) begin
      @(negedge clk);
      #1;
      guard++;
    end
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic logic [12:0] pick_width();
    logic [12:0] w;
    case ($urandom_range(0, 19))
      0:       w = '0;
      1:       w = 13'(MaxDim);
      2:       w = 13'h1FFF;
      3:       w = 13'($urandom_range(MaxDim + 1, 8190));
      4:       w = 13'($urandom_range(0, 8191));
      5, 6:    w = 13'($urandom_range(13, 64));
      default: w = 13'($urandom_range(1, 12));
    endcase
    return w;
  endfunction

  function automatic logic [15:0] pick_height();
    logic [15:0] h;
    case ($urandom_range(0, 19))
      0:       h = '0;
      1:       h = 16'(MaxDim);
      2:       h = 16'hFFFF;
      3:       h = 16'($urandom_range(MaxDim + 1, 65534));
      4:       h = 16'($urandom_range(0, 65535));
      5, 6:    h = 16'($urandom_range(7, 20));
      default: h = 16'($urandom_range(1, 6));
    endcase
    return h;
  endfunction

  initial begin
    int              sent, n, stage;
    logic [3:0]      mask;
    fsr_pkg::depth_e d;
    logic [12:0]     w;
    logic [15:0]     h;
    logic            pat;

    // Power-on state of the mirror matches the block's reset values.
    cur_depth   = fsr_pkg::DEPTH_RGBA32;
    cur_width   = fsr_pkg::FallbackWidth;
    cur_height  = fsr_pkg::FallbackHeight;
    cur_pattern = 1'b0;
    phase       = '0;
    held        = '0;
    col         = '0;
    row         = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults, 32bpp: one full pixel with extreme bytes, then three
    // bytes of a second pixel left hanging.
    fb_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h12, 8'h34, 8'h56};
    settle();

    // RGB565 at 1x1: the pending phase is past the pixel size, so the first
    // byte closes a pixel on the stale low byte; the column left over from
    // the 1024 wide frame is beyond the new row end. Then pure green, and
    // one byte left pending.
    configure(4'b1111, fsr_pkg::DEPTH_RGB565, 13'd1, 16'd1, 1'b0);
    fb_bytes = '{8'hFF, 8'hE0, 8'h07, 8'hAB};
    settle();

    // 24bpp at 2x2, finishing on the held low byte, then a fresh pixel.
    configure(4'b0111, fsr_pkg::DEPTH_RGB24, 13'd2, 16'd2, 1'b0);
    fb_bytes = '{8'hCD, 8'hEF, 8'h10, 8'h20, 8'h30};
    settle();

    // Gray: black and white, closing the 2x2 frame.
    configure(4'b0001, fsr_pkg::DEPTH_GRAY8, 13'd2, 16'd2, 1'b0);
    fb_bytes = '{8'h00, 8'hFF};
    settle();

    // Pattern over eight columns: one pixel of each bar, one frame.
    configure(4'b1110, fsr_pkg::DEPTH_GRAY8, 13'd8, 16'd1, 1'b1);
    fb_bytes = '{8'h5A, 8'hA5, 8'h00, 8'hFF, 8'h11, 8'h22, 8'h33, 8'h44};
    settle();

    // Random phases. The first few pin the extremes of the geometry; after
    // that each phase rewrites a random subset of registers, so some phases
    // change the frame under counters that are mid-row.
    sent  = 0;
    stage = 0;
    while (sent < RandomBytes) begin
      d    = fsr_pkg::depth_e'($urandom_range(0, 3));
      w    = pick_width();
      h    = pick_height();
      pat  = ($urandom_range(0, 4) == 0);
      mask = 4'($urandom_range(1, 15));
      case (stage)
        0: begin
          mask = 4'b1111; d = fsr_pkg::DEPTH_GRAY8; w = 13'h1FFF; h = 16'hFFFF; pat = 1'b0;
        end
        1: begin
          mask = 4'b1111; d = fsr_pkg::DEPTH_RGB565; w = 13'(MaxDim); h = 16'(MaxDim);
          pat = 1'b0;
        end
        2: begin
          mask = 4'b1111; w = '0; h = '0; pat = 1'b1;
        end
        default: ;
      endcase
      configure(mask, d, w, h, pat);
      quiet_src  = ($urandom_range(0, 3) == 0);
      quiet_sink = ($urandom_range(0, 3) == 0);
      n = $urandom_range(8, 80);
      repeat (n) fb_bytes.push_back(8'($urandom_range(0, 255)));
      sent += n;
      stage++;
      settle();
    end

    if (rgba_due.size() > 0)
      $display("%0d expected pixels never arrived", rgba_due.size());
    if (mismatches == 0 && rgba_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/fsr_pkg.sv
rtl/fsr_front.sv
rtl/fsr_queue.sv
rtl/fsr_back.sv
rtl/framebuffer_scanout_to_rgba.sv
dv/framebuffer_scanout_to_rgba_tb.sv
